FILE: rtl/core/substring_masker_assert.svh
// Assertion macros shared by the substring masker checkers
`ifndef SUBSTRING_MASKER_ASSERT_SVH
`define SUBSTRING_MASKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("substring_masker: port check failed");

// Consequent must hold in the cycle after the antecedent
`define SM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("substring_masker: port check failed");

`endif

FILE: rtl/core/sm_pkg.sv
// Shared types and constants of the substring masker
package sm_pkg;

	// Default window depth, longest pattern supported
	localparam int DEF_MAX_PATTERN = 32;

	// Pattern storage and configuration port widths
	localparam int PAT_BYTES  = 32;
	localparam int PAT_WORDS  = 4;
	localparam int WORD_BYTES = 8;
	localparam int LEN_W      = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd1;

	// Replacement byte for matched text
	localparam logic [7:0] MASK_CHAR = 8'h2A;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Front sequencer states
	typedef enum logic [1:0] {
		FR_ACCEPT,
		FR_TRIM,
		FR_FLUSH
	} front_state_t;

	// One result beat on its way from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       masked;
		logic       last;
	} beat_t;

endpackage

FILE: rtl/core/sm_front.sv
// Front: pattern registers, byte window, match test and beat release
module sm_front import sm_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	input  logic [7:0]            text_byte,
	input  logic                  text_end,
	output logic                  full,
	input  logic                  q_full,
	output logic                  beat_valid,
	output beat_t                 beat
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);

	// Configuration
	logic [LEN_W-1:0] len_q;
	logic [7:0]       pat_q [PAT_BYTES];

	// Window, oldest byte at entry 0
	logic [7:0]        win_byte_q [MAX_PATTERN];
	logic              win_mask_q [MAX_PATTERN];
	logic [FILL_W-1:0] fill_q;
	logic              end_q;
	front_state_t      state_q, state_d;

	logic [LEN_W-1:0]  len_clamp;
	logic [FILL_W-1:0] len;
	logic              acc;
	logic [7:0]        cand_byte [MAX_PATTERN];
	logic              cand_mask [MAX_PATTERN];
	logic [FILL_W-1:0] cand_fill;
	logic              hit;
	logic              emit, set_mask, last;
	logic              upd_mask [MAX_PATTERN];

	// Register writes; unused indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
			for (int i = 0; i < PAT_BYTES; i++) pat_q[i] <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_LENGTH) len_q <= cfg_data[LEN_W-1:0];
			for (int w = 0; w < PAT_WORDS; w++) begin
				if (cfg_index == REG_WORD_0 + CFG_IDX_W'(w)) begin
					for (int b = 0; b < WORD_BYTES; b++)
						pat_q[w*WORD_BYTES+b] <= cfg_data[b*8 +: 8];
				end
			end
		end
	end

	// Effective length: zero acts as one, clipped to the window depth
	always_comb begin
		if (len_q == '0) len_clamp = LEN_W'(1);
		else if (len_q > LEN_W'(MAX_PATTERN)) len_clamp = LEN_W'(MAX_PATTERN);
		else len_clamp = len_q;
	end
	assign len = len_clamp[FILL_W-1:0];

	assign full = (state_q != FR_ACCEPT) || q_full;
	assign acc  = push && !full;

	// Window as seen this cycle, with the new byte appended on accept
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (acc && FILL_W'(k) == fill_q) begin
				cand_byte[k] = text_byte;
				cand_mask[k] = 1'b0;
			end else begin
				cand_byte[k] = win_byte_q[k];
				cand_mask[k] = win_mask_q[k];
			end
		end
		cand_fill = acc ? fill_q + FILL_W'(1) : fill_q;
	end

	// Match test over the first len entries; masked bytes never match
	always_comb begin
		hit = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (FILL_W'(k) < len && (cand_mask[k] || cand_byte[k] != pat_q[k]))
				hit = 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_ACCEPT: begin
				if (acc) begin
					if (cand_fill > len) state_d = FR_TRIM;
					else if (text_end) state_d = FR_FLUSH;
				end
			end
			FR_TRIM: begin
				if (!q_full && fill_q <= len) state_d = end_q ? FR_FLUSH : FR_ACCEPT;
			end
			FR_FLUSH: begin
				if (!q_full && fill_q == FILL_W'(1)) state_d = FR_ACCEPT;
			end
			default: state_d = FR_ACCEPT;
		endcase
	end

	// Actions
	always_comb begin
		emit     = 1'b0;
		set_mask = 1'b0;
		last     = 1'b0;
		case (state_q)
			FR_ACCEPT: begin
				if (acc && cand_fill == len) begin
					set_mask = hit;
					emit     = !text_end;
				end
			end
			FR_TRIM: begin
				if (!q_full) begin
					if (fill_q > len) begin
						emit = 1'b1;
					end else begin
						set_mask = hit;
						emit     = !end_q;
					end
				end
			end
			FR_FLUSH: begin
				if (!q_full) begin
					emit = 1'b1;
					last = (fill_q == FILL_W'(1));
				end
			end
			default: ;
		endcase
	end

	// Mask marks after a hit covers the whole window
	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++)
			upd_mask[k] = cand_mask[k] | (set_mask && FILL_W'(k) < len);
	end

	// Window update, shifting down one entry per released beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_byte_q[k] <= '0;
				win_mask_q[k] <= 1'b0;
			end
			fill_q <= '0;
		end else if (emit) begin
			for (int k = 0; k < MAX_PATTERN - 1; k++) begin
				win_byte_q[k] <= cand_byte[k+1];
				win_mask_q[k] <= upd_mask[k+1];
			end
			win_byte_q[MAX_PATTERN-1] <= '0;
			win_mask_q[MAX_PATTERN-1] <= 1'b0;
			fill_q <= cand_fill - FILL_W'(1);
		end else begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_byte_q[k] <= cand_byte[k];
				win_mask_q[k] <= upd_mask[k];
			end
			fill_q <= cand_fill;
		end
	end

	// Sequencer state and held end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_ACCEPT;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) end_q <= text_end;
		end
	end

	// Beat towards the queue
	assign beat_valid  = emit;
	assign beat.data   = cand_byte[0];
	assign beat.masked = upd_mask[0];
	assign beat.last   = last;

endmodule

FILE: rtl/core/sm_queue.sv
// Short queue of result beats between front and back
module sm_queue import sm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	input  beat_t wr_beat,
	output logic  full,
	input  logic  rd_ready,
	output logic  rd_valid,
	output beat_t rd_beat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	beat_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr, do_rd;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_beat  = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && !full;
	assign do_rd    = rd_ready && rd_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wr_ptr_q] <= wr_beat;
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (do_wr && !do_rd) count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

FILE: rtl/core/sm_back.sv
// Back: applies the mask character and holds the result beat
module sm_back import sm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_valid,
	input  beat_t      rd_beat,
	output logic       rd_ready,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       out_end
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic       take;

	assign rd_ready = !valid_q || pop;
	assign take     = rd_valid && rd_ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Payload, masked bytes turn into '*'
	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= rd_beat.masked ? MASK_CHAR : rd_beat.data;
			end_q  <= rd_beat.last;
		end
	end

	assign empty    = !valid_q;
	assign out_byte = byte_q;
	assign out_end  = end_q;

endmodule

FILE: rtl/core/substring_masker.sv
// Streaming substring masker: one text byte per cycle unless full; a result leaves
// once the byte drops out of the pattern-length window. An end byte makes the window
// sequencer flush, one beat per cycle unless the queue is full, up to the pattern
// length; a length cut mid-text first releases the surplus bytes unmatched.
// Asynchronous reset clears window, queue and output stage; length 1, pattern zero.
module substring_masker import sm_pkg::*; #(
	parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            text_byte,
	input  logic                  text_end,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            out_byte,
	output logic                  out_end
);

	logic  q_full, q_wr, q_rd_valid, q_rd_ready;
	beat_t q_wr_beat, q_rd_beat;

	// Window and match sequencer
	sm_front #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.text_byte  (text_byte),
		.text_end   (text_end),
		.full       (full),
		.q_full     (q_full),
		.beat_valid (q_wr),
		.beat       (q_wr_beat)
	);

	// Decoupling queue
	sm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr),
		.wr_beat  (q_wr_beat),
		.full     (q_full),
		.rd_ready (q_rd_ready),
		.rd_valid (q_rd_valid),
		.rd_beat  (q_rd_beat)
	);

	// Result stage
	sm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (q_rd_valid),
		.rd_beat  (q_rd_beat),
		.rd_ready (q_rd_ready),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.out_end  (out_end)
	);

endmodule

FILE: rtl/core/sm_checker.sv
// Port-level checks of the substring masker, bound to the top level
`include "substring_masker_assert.svh"

module sm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       text_end,
	input logic       pop,
	input logic       empty,
	input logic [7:0] out_byte,
	input logic       out_end
);

	// A waiting result beat holds until taken
	`SM_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(out_end))

	// An accepted end byte leads into trim or flush, so input is held off next cycle
	`SM_ASSERT_NEXT(a_end_blocks_input, clk, arst_n, push && !full && text_end, full)

	// Straight out of reset: nothing to deliver and input open
	`SM_ASSERT_SAME(a_reset_state, clk, arst_n, !$past(arst_n), empty && !full)

endmodule

bind substring_masker sm_checker u_sm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.text_end (text_end),
	.pop      (pop),
	.empty    (empty),
	.out_byte (out_byte),
	.out_end  (out_end)
);

FILE: tb/substring_masker_test.sv
// Self-checking testbench for the substring masker: directed cases, then random texts
module substring_masker_test;
	import sm_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_ITEMS  = 170;
	localparam int REG_LAST      = REG_WORD_0 + PAT_WORDS - 1;
	localparam int REG_TOP       = 2 ** CFG_IDX_W - 1;

	// One output beat as predicted
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [7:0]            text_byte = 8'h00;
	logic                  text_end = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            out_byte;
	logic                  out_end;

	bit         steady = 1'b0;
	int         stall_cycles = 0;
	int         random_count = 0;
	logic [7:0] pattern_bytes [PAT_BYTES];

	// Length field as the block uses it: zero acts as one, capped at the window depth
	function automatic int effective_len(logic [LEN_W-1:0] field);
		if (field == 0)
			return 1;
		if (field > DEF_MAX_PATTERN)
			return DEF_MAX_PATTERN;
		return int'(field);
	endfunction

	class mask_scoreboard;
		logic [LEN_W-1:0]      length_reg;
		logic [CFG_DATA_W-1:0] pattern_word [PAT_WORDS];
		logic [7:0]            held_byte [PAT_BYTES];
		bit                    held_masked [PAT_BYTES];
		int                    held_count;
		text_beat_t            expected_beats [$];
		int                    errors;

		function new();
			int k;
			length_reg = LEN_W'(1);
			for (k = 0; k < PAT_WORDS; k++)
				pattern_word[k] = '0;
			for (k = 0; k < PAT_BYTES; k++) begin
				held_byte[k] = 8'h00;
				held_masked[k] = 1'b0;
			end
			held_count = 0;
			errors = 0;
		endfunction

		function void write_reg(int idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_LENGTH)
				length_reg = value[LEN_W-1:0];
			else if (idx >= REG_WORD_0 && idx <= REG_LAST)
				pattern_word[idx - REG_WORD_0] = value;
		endfunction

		function logic [7:0] pattern_byte(int k);
			return pattern_word[k / 8][(k % 8) * 8 +: 8];
		endfunction

		// Oldest held byte leaves the window
		function void release_oldest(bit last);
			text_beat_t b;
			int k;
			b.data = held_masked[0] ? MASK_CHAR : held_byte[0];
			b.last = last;
			expected_beats.push_back(b);
			for (k = 0; k < held_count - 1; k++) begin
				held_byte[k] = held_byte[k + 1];
				held_masked[k] = held_masked[k + 1];
			end
			held_count--;
			held_byte[held_count] = 8'h00;
			held_masked[held_count] = 1'b0;
		endfunction

		// Accepted text beat: shift into the window, test, release
		function void note_byte(logic [7:0] b, logic e);
			int n;
			int k;
			bit hit;
			n = effective_len(length_reg);
			if (held_count >= PAT_BYTES)
				held_count = PAT_BYTES - 1;
			held_byte[held_count] = b;
			held_masked[held_count] = 1'b0;
			held_count++;
			// surplus after a length cut goes out unmatched
			while (held_count > n)
				release_oldest(1'b0);
			if (held_count == n) begin
				hit = 1'b1;
				for (k = 0; k < n; k++)
					if (held_masked[k] || held_byte[k] != pattern_byte(k))
						hit = 1'b0;
				if (hit)
					for (k = 0; k < n; k++)
						held_masked[k] = 1'b1;
				if (!e)
					release_oldest(1'b0);
			end
			if (e)
				while (held_count > 0)
					release_oldest(held_count == 1);
		endfunction

		function void check_beat(logic [7:0] d, logic l);
			text_beat_t want;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual out_byte=%h out_end=%b",
					$time, d, l);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				if (d !== want.data) begin
					$display("%0t: out_byte expected %h actual %h", $time, want.data, d);
					errors++;
				end
				if (l !== want.last) begin
					$display("%0t: out_end expected %b actual %b", $time, want.last, l);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	mask_scoreboard sb = new();

	substring_masker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.text_byte (text_byte),
		.text_end  (text_end),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.out_end   (out_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_beat(out_byte, out_end);
		pop <= steady || ($urandom_range(99) >= 37);
	end

	// Watchdog on cycles without any accepted beat or write
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_write)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic e);
		while (!steady && $urandom_range(99) < 37) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		text_byte <= b;
		text_end <= e;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_byte(b, e);
	endtask

	task automatic send_str(input string s, input bit terminate);
		int k;
		for (k = 0; k < s.len(); k++)
			send_byte(s[k], terminate && k == s.len() - 1);
	endtask

	task automatic set_pattern_str(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			pattern_bytes[k] = s[k];
	endtask

	// Hold off the sender until every expected beat is out and the block is quiet
	task automatic settle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	// Length and all pattern words; bytes past the length get junk
	task automatic load_config(input logic [LEN_W-1:0] len_field, input bit poke_spare);
		logic [CFG_DATA_W-1:0] value;
		int eff;
		int w;
		int j;
		eff = effective_len(len_field);
		settle();
		value = {$urandom, $urandom};
		value[LEN_W-1:0] = len_field;
		write_reg(REG_LENGTH, value);
		for (w = 0; w < PAT_WORDS; w++) begin
			for (j = 0; j < WORD_BYTES; j++)
				value[8 * j +: 8] = (WORD_BYTES * w + j < eff) ?
					pattern_bytes[WORD_BYTES * w + j] : 8'($urandom);
			write_reg(REG_WORD_0 + w, value);
		end
		if (poke_spare)
			write_reg($urandom_range(REG_TOP, REG_LAST + 1), {$urandom, $urandom});
		cfg_write <= 1'b0;
	endtask

	// Text built from pattern copies, prefixes, near-alphabet bytes and noise
	task automatic send_text(input int n, input logic [7:0] base, input bit terminate);
		logic [7:0] body [$];
		int target;
		int r;
		int k;
		int cnt;
		target = $urandom_range(16, 2) + n / 2;
		while (body.size() < target) begin
			r = $urandom_range(99);
			if (r < 45) begin
				for (k = 0; k < n; k++)
					body.push_back(pattern_bytes[k]);
			end else if (r < 60 && n > 1) begin
				cnt = $urandom_range(n - 1, 1);
				for (k = 0; k < cnt; k++)
					body.push_back(pattern_bytes[k]);
			end else if (r < 90) begin
				cnt = $urandom_range(4, 1);
				repeat (cnt) body.push_back(8'(base + $urandom_range(2)));
			end else begin
				cnt = $urandom_range(3, 1);
				repeat (cnt) body.push_back(8'($urandom));
			end
		end
		for (k = 0; k < body.size(); k++)
			send_byte(body[k], terminate && k == body.size() - 1);
		random_count += body.size();
	endtask

	// One setting, then a few texts; the last may stay open across the next write
	task automatic random_phase();
		logic [LEN_W-1:0] len_field;
		logic [7:0] base;
		int r;
		int n;
		int k;
		int texts;
		int t;
		r = $urandom_range(99);
		if (r < 60)
			len_field = LEN_W'($urandom_range(6, 1));
		else if (r < 80)
			len_field = LEN_W'($urandom_range(31, 7));
		else if (r < 90)
			len_field = LEN_W'(DEF_MAX_PATTERN);
		else if (r < 95)
			len_field = LEN_W'($urandom_range(63, 33));
		else
			len_field = '0;
		n = effective_len(len_field);
		base = 8'($urandom);
		for (k = 0; k < PAT_BYTES; k++)
			pattern_bytes[k] = 8'(base + $urandom_range(2));
		load_config(len_field, $urandom_range(3) == 0);
		texts = $urandom_range(3, 1);
		for (t = 0; t < texts; t++)
			send_text(n, base, t < texts - 1 || $urandom_range(4) != 0);
	endtask

	initial begin
		int k;
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: length one, pattern byte zero
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// plain matches, then text shorter than the pattern; spare index poked
		set_pattern_str("abc");
		load_config(3, 1'b1);
		send_str("abcabc", 1'b1);
		send_str("ab", 1'b1);

		// overlapping candidates: only the leftmost is masked
		set_pattern_str("aa");
		load_config(2, 1'b0);
		send_str("aaa", 1'b1);

		// length zero behaves as one
		pattern_bytes[0] = 8'hFF;
		load_config(0, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// oversized length is capped; short text flushes untouched
		for (k = 0; k < PAT_BYTES; k++)
			pattern_bytes[k] = 8'($urandom);
		load_config(63, 1'b0);
		for (k = 0; k < 3; k++)
			send_byte(8'($urandom), k == 2);

		// length cut with pending bytes
		set_pattern_str("wxyz");
		load_config(4, 1'b0);
		send_str("qwx", 1'b0);
		set_pattern_str("xy");
		load_config(2, 1'b0);
		send_byte("y", 1'b1);

		// pattern swapped mid-text
		set_pattern_str("ghi");
		load_config(3, 1'b0);
		send_str("gh", 1'b0);
		set_pattern_str("ghk");
		load_config(3, 1'b0);
		send_byte("k", 1'b1);

		// random phases, one stretch without idling on either side
		phase = 0;
		while (random_count < RANDOM_ITEMS) begin
			steady = (phase == 1 || phase == 2);
			random_phase();
			phase++;
		end
		steady = 1'b0;
		send_byte(8'($urandom), 1'b1);

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
